[hw/rtl/mwf_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Median window filter package
// Shared widths, register indexes, reset values and the sequencer state type.
// ---------------------------------------------------------------------------
package mwf_pkg;

   localparam int PIX_W        = 8;
   localparam int WIDTH_REG_W  = 11;
   localparam int HEIGHT_REG_W = 13;
   localparam int RADIUS_REG_W = 2;
   localparam int CSR_DATA_W   = 13;
   localparam int CSR_INDEX_W  = 2;

   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_WIDTH   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_HEIGHT  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_WINDOW_RADIUS = 2'd2;

   localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd640;
   localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd480;
   localparam logic [RADIUS_REG_W-1:0] RADIUS_RESET = 2'd1;

   // Depth of the result queue; must exceed the step-to-queue latency.
   localparam int FIFO_DEPTH = 8;

   typedef enum logic {
      MWF_RUN,
      MWF_CATCH
   } mwf_state_type;

endpackage

[hw/rtl/mwf_req_if.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Median window filter input channel
// Valid/ready channel that carries one pixel or flush item.
// ---------------------------------------------------------------------------
interface mwf_req_if;
   logic                      valid;
   logic                      ready;
   logic [mwf_pkg::PIX_W-1:0] pixel_in;
   logic                      flush;

   modport source (output valid, output pixel_in, output flush, input ready);
   modport sink   (input valid, input pixel_in, input flush, output ready);
endinterface

[hw/rtl/mwf_rsp_if.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Median window filter result channel
// Valid/ready channel that carries one filtered pixel item.
// ---------------------------------------------------------------------------
interface mwf_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [mwf_pkg::PIX_W-1:0] pixel_out;
   logic                      frame_end;

   modport source (output valid, output pixel_out, output frame_end, input ready);
   modport sink   (input valid, input pixel_out, input frame_end, output ready);
endinterface

[hw/rtl/mwf_ram.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Median window filter RAM
// Simple dual-port RAM, one write and one registered read per cycle.
// ---------------------------------------------------------------------------
module mwf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // A read of the entry written in the same cycle returns the old data.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[hw/rtl/median_window_filter.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Median window filter
// Streaming two-dimensional median over a square window of 8-bit pixels.
// ---------------------------------------------------------------------------
// The block takes one item per clock while ready is high and gives one result
// per centre pixel, delayed by radius rows plus radius pixels in raster order.
// A new item can be taken every cycle, back to back, while ready is high; the
// median of a position passes the registered stages below on its way to the
// result queue. The rate is set by the line store, one RAM of MAX_WIDTH words
// that holds 2*MAX_RADIUS past lines side by side, read and written once per
// step. Results wait in an eight-entry queue, and input is taken as long as the
// queue has room reserved for every result still in flight, so a stalled
// consumer stalls the input only once the queued results and those in flight
// together fill the eight entries. After the last pixel of a frame the host
// sends flush items, one per pending result; a pixel sent then is treated as a
// flush, and a flush sent while pixels are still expected does nothing. The
// result with frame_end set closes the frame and the next item starts a new
// one. A frame so small that the delay reaches past its last pixel (height not
// above the radius, roughly) makes the block step on by itself after the last
// pixel, and no item is taken meanwhile. Register writes belong between frames, while
// the block is idle, and every write restarts the frame; the line store needs
// no clearing after reset, since any entry left from before lies outside the
// current window.
// ---------------------------------------------------------------------------
module median_window_filter #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 4096,
   parameter int MAX_RADIUS = 2
) (
   input  logic                            clock,
   input  logic                            reset,
   mwf_req_if.sink                         req_port,
   mwf_rsp_if.source                       rsp_port,
   input  logic                            csr_we,
   input  logic [mwf_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [mwf_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam int PW    = mwf_pkg::PIX_W;
   localparam int AW    = $clog2(MAX_WIDTH);
   localparam int CW    = $clog2(MAX_WIDTH + 1);
   localparam int RWD   = $clog2(MAX_HEIGHT);
   localparam int HW    = $clog2(MAX_HEIGHT + 1);
   localparam int RB    = $clog2(MAX_RADIUS + 1);
   localparam int EWW   = (CW > mwf_pkg::WIDTH_REG_W) ? CW : mwf_pkg::WIDTH_REG_W;
   localparam int EHW   = (HW > mwf_pkg::HEIGHT_REG_W) ? HW : mwf_pkg::HEIGHT_REG_W;
   localparam int ERW   = (RB > mwf_pkg::RADIUS_REG_W) ? RB : mwf_pkg::RADIUS_REG_W;
   localparam int DW    = CW + RB + 1;
   localparam int MW    = CW + 1;
   localparam int MH    = HW + 1;
   localparam int SIDE  = 2 * MAX_RADIUS + 1;
   localparam int CELLS = SIDE * SIDE;
   localparam int LAGS  = 2 * MAX_RADIUS;
   localparam int CNTW  = $clog2(CELLS + 1);
   localparam int QD    = mwf_pkg::FIFO_DEPTH;
   localparam int QAW   = $clog2(QD);
   localparam int QCW   = $clog2(QD + 1);

   localparam mwf_pkg::mwf_state_type MWF_RUN_C   = mwf_pkg::MWF_RUN;
   localparam mwf_pkg::mwf_state_type MWF_CATCH_C = mwf_pkg::MWF_CATCH;

   // ------------------------------------------------------------------
   // Configuration registers and their effective values.
   // ------------------------------------------------------------------
   logic [mwf_pkg::WIDTH_REG_W-1:0]  width_ff, width_in;
   logic [mwf_pkg::HEIGHT_REG_W-1:0] height_ff, height_in;
   logic [mwf_pkg::RADIUS_REG_W-1:0] radius_ff, radius_in;
   logic                             cfg_hit;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      radius_in = radius_ff;
      cfg_hit   = 1'b0;
      if (csr_we) begin
         case (csr_index)
            mwf_pkg::REG_IMAGE_WIDTH: begin
               width_in = csr_wdata[mwf_pkg::WIDTH_REG_W-1:0];
               cfg_hit  = 1'b1;
            end
            mwf_pkg::REG_IMAGE_HEIGHT: begin
               height_in = csr_wdata[mwf_pkg::HEIGHT_REG_W-1:0];
               cfg_hit   = 1'b1;
            end
            mwf_pkg::REG_WINDOW_RADIUS: begin
               radius_in = csr_wdata[mwf_pkg::RADIUS_REG_W-1:0];
               cfg_hit   = 1'b1;
            end
            default: begin
               cfg_hit = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= mwf_pkg::WIDTH_RESET;
         height_ff <= mwf_pkg::HEIGHT_RESET;
         radius_ff <= mwf_pkg::RADIUS_RESET;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         radius_ff <= radius_in;
      end
   end

   logic [EWW-1:0] width_ext, width_clip;
   logic [EHW-1:0] height_ext, height_clip;
   logic [ERW-1:0] radius_ext, radius_clip;
   logic [CW-1:0]  eff_w;
   logic [HW-1:0]  eff_h;
   logic [RB-1:0]  eff_r;
   logic [DW-1:0]  delay;

   // Width and height are clamped to 1..maximum, the radius saturates.
   always_comb begin
      width_ext  = EWW'(width_ff);
      height_ext = EHW'(height_ff);
      radius_ext = ERW'(radius_ff);
      if (width_ext == '0) width_clip = EWW'(1);
      else if (width_ext > EWW'(MAX_WIDTH)) width_clip = EWW'(MAX_WIDTH);
      else width_clip = width_ext;
      if (height_ext == '0) height_clip = EHW'(1);
      else if (height_ext > EHW'(MAX_HEIGHT)) height_clip = EHW'(MAX_HEIGHT);
      else height_clip = height_ext;
      if (radius_ext > ERW'(MAX_RADIUS)) radius_clip = ERW'(MAX_RADIUS);
      else radius_clip = radius_ext;
      eff_w = width_clip[CW-1:0];
      eff_h = height_clip[HW-1:0];
      eff_r = radius_clip[RB-1:0];
      delay = DW'(eff_r) * DW'(eff_w) + DW'(eff_r);
   end

   // ------------------------------------------------------------------
   // Step sequencer. A step pushes one position (real pixel or drain
   // position) through the line store and the window.
   // ------------------------------------------------------------------
   mwf_pkg::mwf_state_type state_ff, state_in;

   logic [AW-1:0]  vcol_ff, vcol_in;
   logic [RWD-1:0] in_row_ff, in_row_in;
   logic           in_done_ff, in_done_in;
   logic [DW-1:0]  vp_ff, vp_in;
   logic [AW-1:0]  ocol_ff, ocol_in;
   logic [RWD-1:0] orow_ff, orow_in;
   logic [QCW-1:0] credit_ff, credit_in;

   logic accept, pop, step_go, step_emit, step_last, restart;
   logic last_col, last_in_row, out_last_col, out_last_row, vp_at_delay;

   assign req_port.ready = (state_ff == MWF_RUN_C) && (credit_ff != '0);
   assign accept         = req_port.valid && req_port.ready;

   assign last_col     = (CW'(vcol_ff) == eff_w - CW'(1));
   assign last_in_row  = (HW'(in_row_ff) == eff_h - HW'(1));
   assign out_last_col = (CW'(ocol_ff) == eff_w - CW'(1));
   assign out_last_row = (HW'(orow_ff) == eff_h - HW'(1));
   assign vp_at_delay  = (vp_ff == delay);

   always_comb begin
      state_in  = state_ff;
      step_go   = 1'b0;
      step_emit = 1'b0;
      case (state_ff)
         MWF_RUN_C: begin
            if (accept) begin
               if (in_done_ff) begin
                  // All pixels are in: any item drains one result.
                  step_go   = 1'b1;
                  step_emit = 1'b1;
               end else if (!req_port.flush) begin
                  step_go   = 1'b1;
                  step_emit = vp_at_delay;
                  // The last pixel came before the delay was filled: step on
                  // internally until the first centre can be produced.
                  if (last_col && last_in_row && !vp_at_delay) begin
                     state_in = MWF_CATCH_C;
                  end
               end
            end
         end
         MWF_CATCH_C: begin
            step_emit = vp_at_delay;
            step_go   = !vp_at_delay || (credit_ff != '0);
            if (vp_at_delay && step_go) begin
               state_in = MWF_RUN_C;
            end
         end
         default: begin
            state_in = MWF_RUN_C;
         end
      endcase

      step_last = out_last_col && out_last_row;
      restart   = (step_go && step_emit && step_last) || cfg_hit;

      vcol_in    = vcol_ff;
      in_row_in  = in_row_ff;
      in_done_in = in_done_ff;
      vp_in      = vp_ff;
      ocol_in    = ocol_ff;
      orow_in    = orow_ff;
      if (step_go) begin
         vcol_in = last_col ? '0 : vcol_ff + AW'(1);
         if (!in_done_ff && last_col) begin
            if (last_in_row) in_done_in = 1'b1;
            else in_row_in = in_row_ff + RWD'(1);
         end
         if (!vp_at_delay) vp_in = vp_ff + DW'(1);
         if (step_emit) begin
            ocol_in = out_last_col ? '0 : ocol_ff + AW'(1);
            if (out_last_col) orow_in = orow_ff + RWD'(1);
         end
      end
      if (restart) begin
         state_in   = MWF_RUN_C;
         vcol_in    = '0;
         in_row_in  = '0;
         in_done_in = 1'b0;
         vp_in      = '0;
         ocol_in    = '0;
         orow_in    = '0;
      end

      // One queue slot is reserved for every emitting step.
      credit_in = credit_ff - QCW'(step_go && step_emit) + QCW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= MWF_RUN_C;
         vcol_ff    <= '0;
         in_row_ff  <= '0;
         in_done_ff <= 1'b0;
         vp_ff      <= '0;
         ocol_ff    <= '0;
         orow_ff    <= '0;
         credit_ff  <= QCW'(QD);
      end else begin
         state_ff   <= state_in;
         vcol_ff    <= vcol_in;
         in_row_ff  <= in_row_in;
         in_done_ff <= in_done_in;
         vp_ff      <= vp_in;
         ocol_ff    <= ocol_in;
         orow_ff    <= orow_in;
         credit_ff  <= credit_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage 1: line store read returns. Each RAM lane holds the pixel one
   // more line back; the step writes the column shifted down by one lane.
   // ------------------------------------------------------------------
   logic           s1_valid_ff, s1_emit_ff, s1_last_ff;
   logic [PW-1:0]  s1_pix_ff;
   logic [AW-1:0]  s1_addr_ff;
   logic [AW-1:0]  s1_ocol_ff;
   logic [RWD-1:0] s1_orow_ff;

   logic [PW*LAGS-1:0] ram_q, q_eff, ram_wdata;
   logic               fwd_hit_ff, fwd_hit_in;
   logic [PW*LAGS-1:0] fwd_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         fwd_hit_ff  <= 1'b0;
      end else begin
         s1_valid_ff <= step_go;
         fwd_hit_ff  <= fwd_hit_in;
      end
      s1_emit_ff  <= step_emit;
      s1_last_ff  <= step_last;
      s1_pix_ff   <= req_port.pixel_in;
      s1_addr_ff  <= vcol_ff;
      s1_ocol_ff  <= ocol_ff;
      s1_orow_ff  <= orow_ff;
      fwd_data_ff <= ram_wdata;
   end

   mwf_ram #(
      .WIDTH (PW * LAGS),
      .DEPTH (MAX_WIDTH)
   ) u_line_store (
      .clock (clock),
      .we    (s1_valid_ff),
      .waddr (s1_addr_ff),
      .wdata (ram_wdata),
      .raddr (vcol_ff),
      .rdata (ram_q)
   );

   // With a one-pixel line the next step reads the entry being written now.
   assign fwd_hit_in = s1_valid_ff && step_go && (vcol_ff == s1_addr_ff);
   assign q_eff      = fwd_hit_ff ? fwd_data_ff : ram_q;

   always_comb begin
      ram_wdata[PW-1:0] = s1_pix_ff;
      for (int l = 1; l < LAGS; l++) begin
         ram_wdata[l*PW +: PW] = q_eff[(l-1)*PW +: PW];
      end
   end

   // ------------------------------------------------------------------
   // Window: column k is k steps old, row j is j lines up from the newest.
   // ------------------------------------------------------------------
   logic [PW-1:0] wnd_ff [SIDE][SIDE];
   logic [PW-1:0] wnd_in [SIDE][SIDE];

   always_comb begin
      wnd_in = wnd_ff;
      if (s1_valid_ff) begin
         for (int k = 1; k < SIDE; k++) begin
            wnd_in[k] = wnd_ff[k-1];
         end
         wnd_in[0][0] = s1_pix_ff;
         for (int j = 1; j < SIDE; j++) begin
            wnd_in[0][j] = q_eff[(j-1)*PW +: PW];
         end
      end
   end

   always_ff @(posedge clock) begin
      wnd_ff <= wnd_in;
   end

   // ------------------------------------------------------------------
   // Stage 2: in-bounds mask and pairwise order of the window cells.
   // ------------------------------------------------------------------
   logic           s2_valid_ff, s2_last_ff;
   logic [AW-1:0]  s2_ocol_ff;
   logic [RWD-1:0] s2_orow_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff && s1_emit_ff;
      end
      s2_last_ff <= s1_last_ff;
      s2_ocol_ff <= s1_ocol_ff;
      s2_orow_ff <= s1_orow_ff;
   end

   logic [SIDE-1:0]  col_ok, row_ok;
   logic [PW-1:0]    cell_val [CELLS];
   logic [CELLS-1:0] lt_in [CELLS];
   logic [CELLS-1:0] vld_in;
   logic [MW-1:0]    col_base;
   logic [MH-1:0]    row_base;

   always_comb begin
      col_base = MW'(s2_ocol_ff) + MW'(eff_r);
      row_base = MH'(s2_orow_ff) + MH'(eff_r);
      for (int k = 0; k < SIDE; k++) begin
         col_ok[k] = (MW'(k) <= (MW'(eff_r) << 1)) && (col_base >= MW'(k))
                     && ((col_base - MW'(k)) < MW'(eff_w));
         row_ok[k] = (MH'(k) <= (MH'(eff_r) << 1)) && (row_base >= MH'(k))
                     && ((row_base - MH'(k)) < MH'(eff_h));
      end
      for (int k = 0; k < SIDE; k++) begin
         for (int j = 0; j < SIDE; j++) begin
            cell_val[k*SIDE+j] = wnd_ff[k][j];
            vld_in[k*SIDE+j]   = col_ok[k] && row_ok[j];
         end
      end
      // Ties are broken by cell position, so every rank is distinct.
      for (int i = 0; i < CELLS; i++) begin
         for (int m = 0; m < CELLS; m++) begin
            lt_in[i][m] = (cell_val[m] < cell_val[i])
                          || ((cell_val[m] == cell_val[i]) && (m < i));
         end
      end
   end

   logic             s3_valid_ff, s3_last_ff;
   logic [CELLS-1:0] s3_lt_ff [CELLS];
   logic [CELLS-1:0] s3_vld_ff;
   logic [PW-1:0]    s3_val_ff [CELLS];

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff;
      end
      s3_last_ff <= s2_last_ff;
      s3_lt_ff   <= lt_in;
      s3_vld_ff  <= vld_in;
      s3_val_ff  <= cell_val;
   end

   // ------------------------------------------------------------------
   // Stage 3: rank of every valid cell among the valid cells.
   // ------------------------------------------------------------------
   logic [CNTW-1:0] rank_in [CELLS];
   logic [CNTW-1:0] count_in;

   always_comb begin
      count_in = '0;
      for (int m = 0; m < CELLS; m++) begin
         count_in = count_in + CNTW'(s3_vld_ff[m]);
      end
      for (int i = 0; i < CELLS; i++) begin
         rank_in[i] = '0;
         for (int m = 0; m < CELLS; m++) begin
            rank_in[i] = rank_in[i] + CNTW'(s3_vld_ff[m] & s3_lt_ff[i][m]);
         end
      end
   end

   logic             s4_valid_ff, s4_last_ff;
   logic [CNTW-1:0]  s4_rank_ff [CELLS];
   logic [CNTW-1:0]  s4_half_ff;
   logic [CELLS-1:0] s4_vld_ff;
   logic [PW-1:0]    s4_val_ff [CELLS];

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else begin
         s4_valid_ff <= s3_valid_ff;
      end
      s4_last_ff <= s3_last_ff;
      s4_rank_ff <= rank_in;
      s4_half_ff <= count_in >> 1;
      s4_vld_ff  <= s3_vld_ff;
      s4_val_ff  <= s3_val_ff;
   end

   // ------------------------------------------------------------------
   // Stage 4: the cell whose rank is count/2 is the median.
   // ------------------------------------------------------------------
   logic [PW-1:0] med;

   always_comb begin
      med = '0;
      for (int i = 0; i < CELLS; i++) begin
         if (s4_vld_ff[i] && (s4_rank_ff[i] == s4_half_ff)) begin
            med = med | s4_val_ff[i];
         end
      end
   end

   // ------------------------------------------------------------------
   // Result queue.
   // ------------------------------------------------------------------
   logic [PW-1:0]  q_pix_ff [QD];
   logic           q_last_ff [QD];
   logic [QAW-1:0] q_wptr_ff, q_wptr_in, q_rptr_ff, q_rptr_in;
   logic [QCW-1:0] q_count_ff, q_count_in;

   assign rsp_port.valid     = (q_count_ff != '0);
   assign rsp_port.pixel_out = q_pix_ff[q_rptr_ff];
   assign rsp_port.frame_end = q_last_ff[q_rptr_ff];
   assign pop                = rsp_port.valid && rsp_port.ready;

   always_comb begin
      q_wptr_in  = s4_valid_ff ? q_wptr_ff + QAW'(1) : q_wptr_ff;
      q_rptr_in  = pop ? q_rptr_ff + QAW'(1) : q_rptr_ff;
      q_count_in = q_count_ff + QCW'(s4_valid_ff) - QCW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_wptr_ff  <= '0;
         q_rptr_ff  <= '0;
         q_count_ff <= '0;
      end else begin
         q_wptr_ff  <= q_wptr_in;
         q_rptr_ff  <= q_rptr_in;
         q_count_ff <= q_count_in;
      end
      if (s4_valid_ff) begin
         q_pix_ff[q_wptr_ff]  <= med;
         q_last_ff[q_wptr_ff] <= s4_last_ff;
      end
   end

endmodule
